// ----- design/jdz_pkg.sv -----
// Shared types and constants for the joystick dead-zone and change filter.
// Used by every module of the block; depends on nothing.
package jdz_pkg;

	localparam int CFG_W = 16;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic [1:0] CFG_DZ_LOW = 2'd0;
	localparam logic [1:0] CFG_DZ_GAIN = 2'd1;
	localparam logic [1:0] CFG_MARGIN = 2'd2;
	localparam logic [1:0] CFG_TRIG_MODE = 2'd3;

	localparam logic TRIG_SPLIT = 1'b1;
	localparam logic [4:0] CH_TRIG_A = 5'd2;
	localparam logic [4:0] CH_TRIG_B = 5'd5;

	localparam logic signed [15:0] FULL_SCALE = 16'sd32767;
	localparam logic [17:0] FULL_SCALE_U = 18'd32767;
	localparam logic [32:0] ROUND_HALF = 33'd16384;
	localparam logic [7:0] LEVEL_PRESSED = 8'd1;
	localparam logic [7:0] LEVEL_RELEASED = 8'd0;

	typedef enum logic [1:0] {
		EV_AXIS = 2'd0,
		EV_PRESS = 2'd1,
		EV_RELEASE = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [14:0] dz_low;
		logic [15:0] dz_gain;
		logic [14:0] margin;
		logic trig_mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dz_low: 15'd4915,
		dz_gain: 16'd43691,
		margin: 15'd328,
		trig_mode: 1'b0
	};

	typedef struct packed {
		logic is_button;
		logic [3:0] stick;
		logic [4:0] chan;
		logic signed [15:0] value;
		logic [7:0] level;
	} req_t;

endpackage

// ----- design/jdz_front.sv -----
// Front end: accepts samples, remaps trigger axes, drops out-of-range requests
// and applies the dead zone and gain. Depends on jdz_pkg.
module jdz_front #(
	parameter int STICK_COUNT = 16,
	parameter int AXIS_COUNT = 8,
	parameter int BUTTON_COUNT = 32
) (
	input logic clk,
	input logic arst_n,
	input jdz_pkg::cfg_t cfg,
	input logic clearing,
	input logic [jdz_pkg::Q_CNT_W-1:0] q_count,
	input logic sample_valid,
	output logic sample_stall,
	input logic action,
	input logic [3:0] stick,
	input logic [4:0] channel,
	input logic signed [15:0] axis_sample,
	input logic [7:0] button_level,
	output logic push,
	output jdz_pkg::req_t push_req
);
	import jdz_pkg::*;

	logic take;
	logic [Q_CNT_W-1:0] used;
	logic signed [16:0] s_ext;
	logic signed [16:0] s_r;
	logic signed [16:0] s_neg;
	logic [4:0] chan_r;
	logic neg;
	logic [15:0] mag;
	logic dead;
	logic keep;
	logic [32:0] prod;
	logic [14:0] mag_c;

	logic v_s1;
	req_t req_s1;
	logic neg_s1;
	logic dead_s1;
	logic [15:0] d_s1;

	logic v_s2;
	req_t req_s2;
	logic neg_s2;
	logic dead_s2;
	logic [17:0] scaled_s2;

	// Every request in flight has a reserved queue slot, so the stages never stall.
	assign used = q_count + Q_CNT_W'(v_s1) + Q_CNT_W'(v_s2);
	assign sample_stall = clearing || (used >= Q_CNT_W'(Q_DEPTH));
	assign take = sample_valid && !sample_stall;

	always_comb begin
		s_ext = {axis_sample[15], axis_sample};
		s_r = s_ext;
		chan_r = channel;
		if (cfg.trig_mode == TRIG_SPLIT) begin
			if (channel == CH_TRIG_A && axis_sample[15]) begin
				chan_r = CH_TRIG_B;
				s_r = -s_ext;
			end
		end else if (channel == CH_TRIG_A || channel == CH_TRIG_B) begin
			s_r = (s_ext + 17'sd32768) >>> 1;
		end
		neg = s_r[16];
		s_neg = -s_r;
		mag = neg ? s_neg[15:0] : s_r[15:0];
		dead = mag <= {1'b0, cfg.dz_low};
		if ({1'b0, stick} >= 5'(STICK_COUNT)) begin
			keep = 1'b0;
		end else if (action) begin
			keep = {1'b0, channel} < 6'(BUTTON_COUNT);
		end else begin
			keep = {1'b0, chan_r} < 6'(AXIS_COUNT);
		end
	end

	assign prod = 33'(d_s1) * 33'(cfg.dz_gain) + ROUND_HALF;

	always_comb begin
		if (dead_s2) begin
			mag_c = '0;
		end else if (scaled_s2 > FULL_SCALE_U) begin
			mag_c = FULL_SCALE[14:0];
		end else begin
			mag_c = scaled_s2[14:0];
		end
		push_req = req_s2;
		push_req.value = neg_s2 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

	assign push = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take && keep;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		req_s1.is_button <= action;
		req_s1.stick <= stick;
		req_s1.chan <= action ? channel : chan_r;
		req_s1.value <= '0;
		req_s1.level <= button_level;
		neg_s1 <= neg;
		dead_s1 <= dead;
		d_s1 <= mag - {1'b0, cfg.dz_low};
		req_s2 <= req_s1;
		neg_s2 <= neg_s1;
		dead_s2 <= dead_s1;
		scaled_s2 <= prod[32:15];
	end

endmodule

// ----- design/jdz_queue.sv -----
// Short request queue between the front end and the cache back end.
// Depends on jdz_pkg; the front end never pushes into a full queue.
module jdz_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input jdz_pkg::req_t push_req,
	input logic pop,
	output jdz_pkg::req_t head,
	output logic empty,
	output logic [jdz_pkg::Q_CNT_W-1:0] count
);
	import jdz_pkg::*;

	req_t slots [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign head = slots[rd_ptr_q];
	assign empty = count_q == '0;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + Q_CNT_W'(push) - Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_req;
		end
	end

endmodule

// ----- design/jdz_back.sv -----
// Back end: axis and button caches with read-modify-write, change detection
// and the event output register. Depends on jdz_pkg.
module jdz_back #(
	parameter int STICK_COUNT = 16,
	parameter int AXIS_COUNT = 8,
	parameter int BUTTON_COUNT = 32
) (
	input logic clk,
	input logic arst_n,
	input jdz_pkg::cfg_t cfg,
	input jdz_pkg::req_t head,
	input logic q_empty,
	output logic pop,
	output logic clearing,
	output logic event_valid,
	input logic event_stall,
	output jdz_pkg::event_kind_t event_kind,
	output logic [3:0] event_stick,
	output logic [4:0] event_channel,
	output logic signed [15:0] axis_out
);
	import jdz_pkg::*;

	localparam int ADEPTH = STICK_COUNT * AXIS_COUNT;
	localparam int BDEPTH = STICK_COUNT * BUTTON_COUNT;
	localparam int AIDX_W = $clog2(ADEPTH);
	localparam int BIDX_W = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int MAX_DEPTH = (ADEPTH > BDEPTH) ? ADEPTH : BDEPTH;
	localparam int CLR_W = $clog2(MAX_DEPTH);

	logic signed [15:0] amem [ADEPTH];
	logic [7:0] bmem [BDEPTH];

	logic clr_q;
	logic [CLR_W-1:0] clr_cnt_q;

	logic adv;
	logic [AIDX_W-1:0] aidx_rd;
	logic [BIDX_W-1:0] bidx_rd;

	logic v_s1;
	req_t req_s1;
	logic [AIDX_W-1:0] aidx_s1;
	logic [BIDX_W-1:0] bidx_s1;
	logic signed [15:0] ard_s1;
	logic [7:0] brd_s1;

	logic lwa_v_q;
	logic [AIDX_W-1:0] lwa_idx_q;
	logic signed [15:0] lwa_d_q;
	logic lwb_v_q;
	logic [BIDX_W-1:0] lwb_idx_q;
	logic [7:0] lwb_d_q;

	logic signed [15:0] acur;
	logic [7:0] bcur;
	logic signed [16:0] dv;
	logic [16:0] absd;
	logic [14:0] thr;
	logic a_wr;
	logic b_wr;
	logic emit;
	event_kind_t kind;

	logic ev_valid_q;
	event_kind_t ev_kind_q;
	logic [3:0] ev_stick_q;
	logic [4:0] ev_chan_q;
	logic signed [15:0] ev_axis_q;

	assign clearing = clr_q;
	assign adv = !ev_valid_q || !event_stall;
	assign pop = adv && !q_empty && !clr_q;

	assign aidx_rd = head.is_button ? '0
		: AIDX_W'(int'(head.stick) * AXIS_COUNT + int'(head.chan));
	assign bidx_rd = head.is_button
		? BIDX_W'(int'(head.stick) * BUTTON_COUNT + int'(head.chan)) : '0;

	// The entry written at the edge of this request's read is forwarded here.
	always_comb begin
		acur = (lwa_v_q && lwa_idx_q == aidx_s1) ? lwa_d_q : ard_s1;
		bcur = (lwb_v_q && lwb_idx_q == bidx_s1) ? lwb_d_q : brd_s1;
		dv = {req_s1.value[15], req_s1.value} - {acur[15], acur};
		absd = dv[16] ? 17'(-dv) : 17'(dv);
		if (req_s1.value == '0 || req_s1.value == FULL_SCALE || req_s1.value == -FULL_SCALE) begin
			thr = '0;
		end else begin
			thr = cfg.margin;
		end
		a_wr = v_s1 && !req_s1.is_button && (absd > {2'b0, thr});
		b_wr = v_s1 && req_s1.is_button && (req_s1.level != bcur);
		emit = a_wr || (b_wr && (req_s1.level == LEVEL_PRESSED
			|| req_s1.level == LEVEL_RELEASED));
		if (!req_s1.is_button) begin
			kind = EV_AXIS;
		end else if (req_s1.level == LEVEL_PRESSED) begin
			kind = EV_PRESS;
		end else begin
			kind = EV_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			v_s1 <= 1'b0;
			lwa_v_q <= 1'b0;
			lwb_v_q <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_W'(MAX_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1 <= pop;
				lwa_v_q <= a_wr;
				lwb_v_q <= b_wr;
				ev_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1 <= head;
			aidx_s1 <= aidx_rd;
			bidx_s1 <= bidx_rd;
			ard_s1 <= amem[aidx_rd];
			brd_s1 <= bmem[bidx_rd];
		end
		if (adv) begin
			lwa_idx_q <= aidx_s1;
			lwa_d_q <= req_s1.value;
			lwb_idx_q <= bidx_s1;
			lwb_d_q <= req_s1.level;
			if (emit) begin
				ev_kind_q <= kind;
				ev_stick_q <= req_s1.stick;
				ev_chan_q <= req_s1.chan;
				ev_axis_q <= req_s1.is_button ? '0 : req_s1.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			if ({1'b0, clr_cnt_q} < (CLR_W + 1)'(ADEPTH)) begin
				amem[clr_cnt_q[AIDX_W-1:0]] <= '0;
			end
			if ({1'b0, clr_cnt_q} < (CLR_W + 1)'(BDEPTH)) begin
				bmem[BIDX_W'(clr_cnt_q)] <= '0;
			end
		end else if (adv) begin
			if (a_wr) begin
				amem[aidx_s1] <= req_s1.value;
			end
			if (b_wr) begin
				bmem[bidx_s1] <= req_s1.level;
			end
		end
	end

	assign event_valid = ev_valid_q;
	assign event_kind = ev_kind_q;
	assign event_stick = ev_stick_q;
	assign event_channel = ev_chan_q;
	assign axis_out = ev_axis_q;

endmodule

// ----- design/joystick_dead_zone_change_filter.sv -----
// Joystick dead-zone and change filter: accepts one sample per cycle unless stalled;
// a sample passes the front-end stages, the queue, the back-end read stage and the
// output register. Throughput is one request per cycle while the output is not
// stalled, set by the cache read-modify-write; a stalled output backs up through
// a four-entry queue. After reset the caches are zeroed by a pass over max(STICK_COUNT*
// AXIS_COUNT, STICK_COUNT*BUTTON_COUNT) entries (512 by default) while samples are stalled.
module joystick_dead_zone_change_filter #(
	parameter int STICK_COUNT = 16,
	parameter int AXIS_COUNT = 8,
	parameter int BUTTON_COUNT = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [1:0] cfg_index,
	input logic [jdz_pkg::CFG_W-1:0] cfg_data,
	input logic sample_valid,
	output logic sample_stall,
	input logic action,
	input logic [3:0] stick,
	input logic [4:0] channel,
	input logic signed [15:0] axis_sample,
	input logic [7:0] button_level,
	output logic event_valid,
	input logic event_stall,
	output jdz_pkg::event_kind_t event_kind,
	output logic [3:0] event_stick,
	output logic [4:0] event_channel,
	output logic signed [15:0] axis_out
);
	import jdz_pkg::*;

	cfg_t cfg_q;
	logic clearing;
	logic push;
	req_t push_req;
	logic pop;
	req_t head;
	logic q_empty;
	logic [Q_CNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DZ_LOW: cfg_q.dz_low <= cfg_data[14:0];
				CFG_DZ_GAIN: cfg_q.dz_gain <= cfg_data;
				CFG_MARGIN: cfg_q.margin <= cfg_data[14:0];
				CFG_TRIG_MODE: cfg_q.trig_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	jdz_front #(
		.STICK_COUNT(STICK_COUNT),
		.AXIS_COUNT(AXIS_COUNT),
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.clearing(clearing),
		.q_count(q_count),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.action(action),
		.stick(stick),
		.channel(channel),
		.axis_sample(axis_sample),
		.button_level(button_level),
		.push(push),
		.push_req(push_req)
	);

	jdz_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_req(push_req),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.count(q_count)
	);

	jdz_back #(
		.STICK_COUNT(STICK_COUNT),
		.AXIS_COUNT(AXIS_COUNT),
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.clearing(clearing),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_kind(event_kind),
		.event_stick(event_stick),
		.event_channel(event_channel),
		.axis_out(axis_out)
	);

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for joystick_dead_zone_change_filter: directed and random requests
// against a built-in predictor of the dead zone, trigger remap and change filter.
// Depends on jdz_pkg and the joystick_dead_zone_change_filter top level.
module tb_top;
	import jdz_pkg::*;

	localparam int STICKS = 16;
	localparam int AXES = 8;
	localparam int BUTTONS = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		event_kind_t kind;
		logic [3:0] stick;
		logic [4:0] chan;
		logic signed [15:0] axis;
	} stick_event_t;

	class stick_event_board;
		cfg_t cfg;
		logic signed [15:0] axis_cache [STICKS*AXES];
		logic [7:0] button_cache [STICKS*BUTTONS];
		stick_event_t due_events [$];
		int fails;

		function new();
			cfg = CFG_RESET;
			foreach (axis_cache[i]) axis_cache[i] = '0;
			foreach (button_cache[i]) button_cache[i] = '0;
			fails = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [CFG_W-1:0] data);
			case (index)
				CFG_DZ_LOW: cfg.dz_low = data[14:0];
				CFG_DZ_GAIN: cfg.dz_gain = data;
				CFG_MARGIN: cfg.margin = data[14:0];
				CFG_TRIG_MODE: cfg.trig_mode = data[0];
				default: ;
			endcase
		endfunction

		function int shape_axis(int s);
			int unsigned mag;
			longint p;
			mag = s < 0 ? -s : s;
			if (mag <= cfg.dz_low)
				return 0;
			p = (longint'(mag) - longint'(cfg.dz_low)) * longint'(cfg.dz_gain) + 16384;
			p = p >> 15;
			if (p > 32767)
				p = 32767;
			return s < 0 ? -int'(p) : int'(p);
		endfunction

		function void note_sample(logic act, logic [3:0] stk, logic [4:0] ch,
				logic signed [15:0] smp, logic [7:0] lvl);
			int s, v, c, diff, thr, ax, idx;
			stick_event_t ev;
			if (stk >= STICKS)
				return;
			if (!act) begin
				s = smp;
				ax = ch;
				if (cfg.trig_mode == TRIG_SPLIT) begin
					if (ch == CH_TRIG_A && s < 0) begin
						ax = CH_TRIG_B;
						s = -s;
					end
				end else if (ch == CH_TRIG_A || ch == CH_TRIG_B) begin
					s = (s + 32768) >>> 1;
				end
				if (ax >= AXES)
					return;
				v = shape_axis(s);
				idx = stk * AXES + ax;
				c = axis_cache[idx];
				diff = v - c;
				if (diff < 0)
					diff = -diff;
				thr = (v == 0 || v == int'(FULL_SCALE) || v == -int'(FULL_SCALE)) ?
					0 : int'(cfg.margin);
				if (diff > thr) begin
					axis_cache[idx] = 16'(v);
					ev.kind = EV_AXIS;
					ev.stick = stk;
					ev.chan = 5'(ax);
					ev.axis = 16'(v);
					due_events.push_back(ev);
				end
			end else begin
				if (ch >= BUTTONS)
					return;
				idx = stk * BUTTONS + ch;
				if (lvl == button_cache[idx])
					return;
				button_cache[idx] = lvl;
				if (lvl > LEVEL_PRESSED)
					return;
				ev.kind = (lvl == LEVEL_PRESSED) ? EV_PRESS : EV_RELEASE;
				ev.stick = stk;
				ev.chan = ch;
				ev.axis = '0;
				due_events.push_back(ev);
			end
		endfunction

		function void check_event(event_kind_t kind, logic [3:0] stk, logic [4:0] ch,
				logic signed [15:0] axis);
			stick_event_t ev;
			if (due_events.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("Unexpected event: kind %0d stick %0d channel %0d axis %0d",
						kind, stk, ch, axis);
				return;
			end
			ev = due_events.pop_front();
			if (ev.kind !== kind || ev.stick !== stk || ev.chan !== ch || ev.axis !== axis) begin
				fails++;
				if (fails <= 10)
					$display("Event mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						ev.kind, ev.stick, ev.chan, ev.axis, kind, stk, ch, axis);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = CFG_DZ_LOW;
	logic [CFG_W-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic action = 1'b0;
	logic [3:0] stick = '0;
	logic [4:0] channel = '0;
	logic signed [15:0] axis_sample = '0;
	logic [7:0] button_level = '0;
	logic event_valid;
	logic event_stall = 1'b0;
	event_kind_t event_kind;
	logic [3:0] event_stick;
	logic [4:0] event_channel;
	logic signed [15:0] axis_out;

	stick_event_board board = new();
	int unsigned cycles = 0;
	logic quiet = 1'b0;

	joystick_dead_zone_change_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.action(action),
		.stick(stick),
		.channel(channel),
		.axis_sample(axis_sample),
		.button_level(button_level),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_kind(event_kind),
		.event_stick(event_stick),
		.event_channel(event_channel),
		.axis_out(axis_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL joystick_dead_zone_change_filter");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall)
			board.check_event(event_kind, event_stick, event_channel, axis_out);
		event_stall <= !quiet && ($urandom_range(99) < 24);
	end

	task automatic send_sample(logic act, logic [3:0] stk, logic [4:0] ch,
			logic signed [15:0] smp, logic [7:0] lvl);
		while (!quiet && $urandom_range(99) < 24) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		action <= act;
		stick <= stk;
		channel <= ch;
		axis_sample <= smp;
		button_level <= lvl;
		do @(posedge clk); while (sample_stall);
		board.note_sample(act, stk, ch, smp, lvl);
	endtask

	task automatic write_config(logic [CFG_W-1:0] low, logic [CFG_W-1:0] gain,
			logic [CFG_W-1:0] margin, logic [CFG_W-1:0] mode);
		logic [1:0] regs [4];
		logic [CFG_W-1:0] vals [4];
		regs = '{CFG_DZ_LOW, CFG_DZ_GAIN, CFG_MARGIN, CFG_TRIG_MODE};
		vals = '{low, gain, margin, mode};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			board.write_reg(regs[i], vals[i]);
		end
		cfg_write <= 1'b0;
	endtask

	task automatic settle();
		int n;
		n = 0;
		sample_valid <= 1'b0;
		while (board.due_events.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random();
		logic act;
		logic [3:0] stk;
		logic [4:0] ch;
		logic signed [15:0] smp;
		logic [7:0] lvl;
		int lo, mag;
		act = $urandom_range(99) >= 55;
		stk = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom);
		ch = 5'($urandom);
		smp = 16'($urandom);
		lvl = 8'($urandom);
		lo = board.cfg.dz_low;
		if (!act) begin
			if ($urandom_range(99) < 90)
				ch = 5'($urandom_range(AXES - 1));
			case ($urandom_range(4))
				0: ;
				1: begin
					case ($urandom_range(3))
						0: smp = -16'sd32768;
						1: smp = 16'sd32767;
						2: smp = 16'sd0;
						default: smp = -16'sd32767;
					endcase
				end
				2: begin
					mag = lo + $urandom_range(2) - 1;
					smp = 16'($urandom_range(1) ? -mag : mag);
				end
				default: begin
					mag = lo + $urandom_range(3000);
					if (mag > 32768)
						mag = 32768;
					smp = 16'($urandom_range(1) ? -mag : mag);
				end
			endcase
		end else begin
			if ($urandom_range(99) < 70)
				ch = 5'($urandom_range(3));
			case ($urandom_range(9))
				0: ;
				1, 2, 3, 4, 5: lvl = LEVEL_PRESSED;
				default: lvl = LEVEL_RELEASED;
			endcase
		end
		send_sample(act, stk, ch, smp, lvl);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_config(16'd4915, 16'd43691, 16'd328, 16'd0);
		send_sample(1'b0, 4'd0, 5'd0, 16'sd32767, 8'd0);
		send_sample(1'b0, 4'd0, 5'd0, -16'sd32768, 8'd0);
		send_sample(1'b0, 4'd0, 5'd0, 16'sd4915, 8'd0);
		send_sample(1'b0, 4'd0, 5'd0, 16'sd4916, 8'd0);
		send_sample(1'b0, 4'd0, 5'd1, -16'sd4916, 8'd0);
		send_sample(1'b0, 4'd0, 5'd2, -16'sd32768, 8'd0);
		send_sample(1'b0, 4'd0, 5'd2, 16'sd32767, 8'd0);
		send_sample(1'b0, 4'd0, 5'd5, -16'sd1, 8'd0);
		send_sample(1'b0, 4'd0, 5'd7, -16'sd20000, 8'd0);
		send_sample(1'b0, 4'd0, 5'd8, 16'sd12000, 8'd0);
		send_sample(1'b0, 4'd15, 5'd31, -16'sd1, 8'd0);
		send_sample(1'b0, 4'd15, 5'd7, 16'sd32767, 8'd0);
		send_sample(1'b1, 4'd0, 5'd0, 16'sd0, LEVEL_PRESSED);
		send_sample(1'b1, 4'd0, 5'd0, 16'sd0, LEVEL_PRESSED);
		send_sample(1'b1, 4'd0, 5'd0, 16'sd0, LEVEL_RELEASED);
		send_sample(1'b1, 4'd15, 5'd31, -16'sd1, 8'hFF);
		send_sample(1'b1, 4'd15, 5'd31, 16'sd0, LEVEL_PRESSED);
		send_sample(1'b1, 4'd15, 5'd31, 16'sd0, 8'd2);
		send_sample(1'b1, 4'd15, 5'd31, 16'sd0, LEVEL_RELEASED);
		settle();

		write_config(16'd4915, 16'd43691, 16'd328, 16'd1);
		send_sample(1'b0, 4'd3, 5'd2, -16'sd32768, 8'd0);
		send_sample(1'b0, 4'd3, 5'd2, 16'sd12345, 8'd0);
		send_sample(1'b0, 4'd3, 5'd5, -16'sd32768, 8'd0);
		send_sample(1'b0, 4'd3, 5'd2, -16'sd1, 8'd0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_config(16'd0, 16'hFFFF, 16'd0, 16'd1);
				1: write_config(16'd1000, 16'd40000, 16'd200, 16'd0);
				2: write_config(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'd1);
				3: write_config(16'd200, 16'd0, 16'd50, 16'd0);
				default: write_config({1'($urandom), 15'($urandom_range(8000))}, 16'($urandom),
					{1'($urandom), 15'($urandom_range(1000))}, 16'($urandom));
			endcase
			quiet <= (ph == 1);
			repeat (285) send_random();
			settle();
		end

		if (board.fails == 0 && board.due_events.size() == 0)
			$display("PASS joystick_dead_zone_change_filter");
		else
			$display("FAIL joystick_dead_zone_change_filter");
		$finish;
	end
endmodule
